@@ src/rgbhsl_pkg.sv @@
// Shared types, widths and constants for the RGB to HSL converter.
// No dependencies; every other file in src refers to it by scoped names.
package rgbhsl_pkg;

    localparam int ChanW  = 8;
    localparam int LightW = 9;
    localparam int HueW   = 15;
    localparam int SatW   = 16;

    // Divider operands: numerator, doubled divisor, quotient and low numerator part widths.
    localparam int NumW   = 25;
    localparam int DenW   = 9;
    localparam int QuotW  = 16;
    localparam int LowW   = NumW - DenW;
    localparam int Stages = QuotW;

    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Hue sector offsets in units of 60 degrees.
    localparam logic [2:0] OFF_RED      = 3'd0;
    localparam logic [2:0] OFF_RED_WRAP = 3'd6;
    localparam logic [2:0] OFF_GREEN    = 3'd2;
    localparam logic [2:0] OFF_BLUE     = 3'd4;

    localparam logic [LightW-1:0] LIGHT_HALF = 9'd255;
    localparam logic [LightW-1:0] LIGHT_FULL = 9'd510;
    localparam logic [NumW-1:0]   HUE_SCALE2 = 25'd7680;
    localparam logic [QuotW-1:0]  HUE_LIMIT  = 16'd23040;
    localparam logic [DenW-1:0]   DEN_IDLE   = 9'd2;

    typedef struct packed {
        logic [NumW-1:0]   sat_num;
        logic [DenW-1:0]   sat_den;
        logic [NumW-1:0]   hue_num;
        logic [DenW-1:0]   hue_den;
        logic [LightW-1:0] light;
    } t_work;

    // One restoring division step: returns the quotient bit above the new remainder.
    function automatic logic [DenW:0] div_step(input logic [DenW-1:0] rem,
                                               input logic            nbit,
                                               input logic [DenW-1:0] den);
        logic [DenW:0] t;
        logic          ge;
        t  = {rem, nbit};
        ge = (t >= {1'b0, den});
        if (ge) begin
            return {1'b1, DenW'(t - {1'b0, den})};
        end else begin
            return {1'b0, t[DenW-1:0]};
        end
    endfunction

endpackage

@@ src/rgbhsl_front.sv @@
// Front end: channel max/min, chroma, hue sector and divider operands.
// Two register stages; depends on rgbhsl_pkg.
module rgbhsl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [rgbhsl_pkg::ChanW-1:0]       i_red,
    input  logic [rgbhsl_pkg::ChanW-1:0]       i_green,
    input  logic [rgbhsl_pkg::ChanW-1:0]       i_blue,
    output logic                               o_valid,
    input  logic                               i_ready,
    output rgbhsl_pkg::t_work                  o_work
);

    logic                              adv;
    logic [rgbhsl_pkg::ChanW-1:0]      mx, mn;
    logic [2:0]                        off;
    logic signed [rgbhsl_pkg::ChanW:0] diff;

    logic                              r_vld1, n_vld1;
    logic [rgbhsl_pkg::ChanW-1:0]      r_c;
    logic [rgbhsl_pkg::LightW-1:0]     r_s;
    logic [2:0]                        r_off;
    logic signed [rgbhsl_pkg::ChanW:0] r_diff;

    logic                              r_vld2, n_vld2;
    rgbhsl_pkg::t_work                 r_work, n_work;

    logic [rgbhsl_pkg::ChanW-1:0]      d;
    logic [10:0]                       oc;
    logic signed [11:0]                vsum;
    logic [10:0]                       v;

    assign adv     = !r_vld2 || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld2;
    assign o_work  = r_work;

    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        if (i_blue > mx) begin
            mx = i_blue;
        end
        mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < mn) begin
            mn = i_blue;
        end
        priority if (mx == i_red) begin
            diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            off  = (i_green < i_blue) ? rgbhsl_pkg::OFF_RED_WRAP : rgbhsl_pkg::OFF_RED;
        end else if (mx == i_green) begin
            diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
            off  = rgbhsl_pkg::OFF_GREEN;
        end else begin
            diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
            off  = rgbhsl_pkg::OFF_BLUE;
        end
    end

    // The hue numerator folds the sector offset in: (off * c + diff) is never negative.
    always_comb begin
        d    = (r_s > rgbhsl_pkg::LIGHT_HALF) ? 8'(rgbhsl_pkg::LIGHT_FULL - r_s) : r_s[7:0];
        oc   = 11'(r_off) * 11'(r_c);
        vsum = $signed({1'b0, oc}) + $signed({{3{r_diff[8]}}, r_diff});
        v    = vsum[10:0];
        n_work.light = r_s;
        if (r_c == '0) begin
            n_work.sat_num = '0;
            n_work.sat_den = rgbhsl_pkg::DEN_IDLE;
            n_work.hue_num = '0;
            n_work.hue_den = rgbhsl_pkg::DEN_IDLE;
        end else begin
            n_work.sat_num = (25'(r_c) << 17) - (25'(r_c) << 1) + 25'(d);
            n_work.sat_den = {d, 1'b0};
            n_work.hue_num = 25'(v) * rgbhsl_pkg::HUE_SCALE2 + 25'(r_c);
            n_work.hue_den = {r_c, 1'b0};
        end
        n_vld1 = adv ? i_valid : r_vld1;
        n_vld2 = adv ? r_vld1 : r_vld2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= n_vld1;
            r_vld2 <= n_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c    <= mx - mn;
            r_s    <= 9'(mx) + 9'(mn);
            r_off  <= off;
            r_diff <= diff;
            r_work <= n_work;
        end
    end

endmodule

@@ src/rgbhsl_queue.sv @@
// Short word queue between the front end and the divider pipeline.
// Depends on rgbhsl_pkg for the word type and depth.
module rgbhsl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rgbhsl_pkg::t_work i_work,
    output logic              o_valid,
    input  logic              i_ready,
    output rgbhsl_pkg::t_work o_work
);

    rgbhsl_pkg::t_work               r_mem [rgbhsl_pkg::QDepth];
    logic [rgbhsl_pkg::QPtrW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [rgbhsl_pkg::QCntW-1:0]    r_cnt, n_cnt;
    logic                            wr, rd;

    assign o_ready = (r_cnt != rgbhsl_pkg::QCntW'(rgbhsl_pkg::QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_work  = r_mem[r_rd];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr) begin
            n_wr = (r_wr == rgbhsl_pkg::QPtrW'(rgbhsl_pkg::QDepth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd) begin
            n_rd = (r_rd == rgbhsl_pkg::QPtrW'(rgbhsl_pkg::QDepth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= i_work;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rgbhsl_pkg::QCntW'(rgbhsl_pkg::QDepth))
        else $error("queue count exceeds depth");

endmodule

@@ src/rgbhsl_back.sv @@
// Back end: two pipelined restoring dividers, one quotient bit per stage,
// for saturation and hue. Depends on rgbhsl_pkg.
module rgbhsl_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  rgbhsl_pkg::t_work                 i_work,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [rgbhsl_pkg::HueW-1:0]       o_hue,
    output logic [rgbhsl_pkg::SatW-1:0]       o_sat,
    output logic [rgbhsl_pkg::LightW-1:0]     o_light
);

    localparam int NS = rgbhsl_pkg::Stages;

    logic                            adv;
    logic                            r_vld   [NS];
    logic [rgbhsl_pkg::DenW-1:0]     r_rem_s [NS];
    logic [rgbhsl_pkg::DenW-1:0]     r_rem_h [NS];
    logic [rgbhsl_pkg::LowW-1:0]     r_num_s [NS];
    logic [rgbhsl_pkg::LowW-1:0]     r_num_h [NS];
    logic [rgbhsl_pkg::QuotW-1:0]    r_q_s   [NS];
    logic [rgbhsl_pkg::QuotW-1:0]    r_q_h   [NS];
    logic [rgbhsl_pkg::DenW-1:0]     r_den_s [NS];
    logic [rgbhsl_pkg::DenW-1:0]     r_den_h [NS];
    logic [rgbhsl_pkg::LightW-1:0]   r_light [NS];

    logic                            n_vld   [NS];
    logic [rgbhsl_pkg::DenW-1:0]     n_rem_s [NS];
    logic [rgbhsl_pkg::DenW-1:0]     n_rem_h [NS];
    logic [rgbhsl_pkg::LowW-1:0]     n_num_s [NS];
    logic [rgbhsl_pkg::LowW-1:0]     n_num_h [NS];
    logic [rgbhsl_pkg::QuotW-1:0]    n_q_s   [NS];
    logic [rgbhsl_pkg::QuotW-1:0]    n_q_h   [NS];
    logic [rgbhsl_pkg::DenW-1:0]     n_den_s [NS];
    logic [rgbhsl_pkg::DenW-1:0]     n_den_h [NS];
    logic [rgbhsl_pkg::LightW-1:0]   n_light [NS];

    assign adv     = !r_vld[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NS-1];
    assign o_hue   = r_q_h[NS-1][rgbhsl_pkg::HueW-1:0];
    assign o_sat   = r_q_s[NS-1];
    assign o_light = r_light[NS-1];

    // The top numerator bits start as the remainder; the quotient is known to
    // fit in QuotW bits, so each stage retires one more numerator bit.
    always_comb begin
        logic [rgbhsl_pkg::DenW-1:0]  rs, rh, ds, dh;
        logic [rgbhsl_pkg::LowW-1:0]  ns, nh;
        logic [rgbhsl_pkg::QuotW-1:0] qs, qh;
        logic [rgbhsl_pkg::DenW:0]    st, sh;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                rs = i_work.sat_num[rgbhsl_pkg::NumW-1:rgbhsl_pkg::LowW];
                ns = i_work.sat_num[rgbhsl_pkg::LowW-1:0];
                rh = i_work.hue_num[rgbhsl_pkg::NumW-1:rgbhsl_pkg::LowW];
                nh = i_work.hue_num[rgbhsl_pkg::LowW-1:0];
                qs = '0;
                qh = '0;
                ds = i_work.sat_den;
                dh = i_work.hue_den;
                n_light[k] = i_work.light;
                n_vld[k]   = i_valid;
            end else begin
                rs = r_rem_s[k-1];
                ns = r_num_s[k-1];
                rh = r_rem_h[k-1];
                nh = r_num_h[k-1];
                qs = r_q_s[k-1];
                qh = r_q_h[k-1];
                ds = r_den_s[k-1];
                dh = r_den_h[k-1];
                n_light[k] = r_light[k-1];
                n_vld[k]   = r_vld[k-1];
            end
            st = rgbhsl_pkg::div_step(rs, ns[rgbhsl_pkg::LowW-1], ds);
            sh = rgbhsl_pkg::div_step(rh, nh[rgbhsl_pkg::LowW-1], dh);
            n_rem_s[k] = st[rgbhsl_pkg::DenW-1:0];
            n_rem_h[k] = sh[rgbhsl_pkg::DenW-1:0];
            n_q_s[k]   = {qs[rgbhsl_pkg::QuotW-2:0], st[rgbhsl_pkg::DenW]};
            n_q_h[k]   = {qh[rgbhsl_pkg::QuotW-2:0], sh[rgbhsl_pkg::DenW]};
            n_num_s[k] = {ns[rgbhsl_pkg::LowW-2:0], 1'b0};
            n_num_h[k] = {nh[rgbhsl_pkg::LowW-2:0], 1'b0};
            n_den_s[k] = ds;
            n_den_h[k] = dh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NS; k++) begin
                r_rem_s[k] <= n_rem_s[k];
                r_rem_h[k] <= n_rem_h[k];
                r_num_s[k] <= n_num_s[k];
                r_num_h[k] <= n_num_h[k];
                r_q_s[k]   <= n_q_s[k];
                r_q_h[k]   <= n_q_h[k];
                r_den_s[k] <= n_den_s[k];
                r_den_h[k] <= n_den_h[k];
                r_light[k] <= n_light[k];
            end
        end
    end

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_q_h[NS-1] < rgbhsl_pkg::HUE_LIMIT))
        else $error("hue quotient out of range");

    a_sat_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_rem_s[NS-1] < r_den_s[NS-1]))
        else $error("saturation remainder not below divisor");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_light == '0)) |-> ((o_hue == '0) && (o_sat == '0)))
        else $error("black pixel with nonzero hue or saturation");

endmodule

@@ src/rgb_to_hsl_converter_top.sv @@
// Top level of the RGB to HSL converter: front end, word queue, divider back end.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_queue and rgbhsl_back.
//
// Usage:
//   Input channel i_valid/o_ready carries one pixel word (i_red_in, i_green_in,
//   i_blue_in). Output channel o_valid/i_ready carries one result word
//   (o_hue_out in 1/64 degree, o_saturation_out as Q0.16, o_lightness_out as
//   max plus min). Every pixel gives exactly one result, in order.
//   Throughput is one pixel per clock while the receiver does not stall. Each
//   result passes through the two front-end stages, one queue slot and the
//   16-stage divider pipeline (one quotient bit per stage).
//   Reset empties all stages and the queue; no state is carried between pixels.
//   When the receiver stalls, the divider pipeline holds, while the front end
//   keeps accepting until the two-word queue and its own output stage are full.
module rgb_to_hsl_converter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [rgbhsl_pkg::ChanW-1:0]      i_red_in,
    input  logic [rgbhsl_pkg::ChanW-1:0]      i_green_in,
    input  logic [rgbhsl_pkg::ChanW-1:0]      i_blue_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [rgbhsl_pkg::HueW-1:0]       o_hue_out,
    output logic [rgbhsl_pkg::SatW-1:0]       o_saturation_out,
    output logic [rgbhsl_pkg::LightW-1:0]     o_lightness_out
);

    logic              f_valid, f_ready, q_valid, q_ready;
    rgbhsl_pkg::t_work f_work, q_work;

    rgbhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_work  (f_work)
    );

    rgbhsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_work  (f_work),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_work  (q_work)
    );

    rgbhsl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_work  (q_work),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hue   (o_hue_out),
        .o_sat   (o_saturation_out),
        .o_light (o_lightness_out)
    );

endmodule
